@@ design/wahp_pkg.sv @@
// Shared types and constants for the WAV/AIFF header parser.
// Holds chunk tags, status codes, parse phases and flag bit positions; no dependencies.
`default_nettype none

package wahp_pkg;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_PRE    = 6'b000010,
    PH_HDR    = 6'b000100,
    PH_FIELDS = 6'b001000,
    PH_SKIP   = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_MAGIC  = 3'd1,
    ST_BAD_FORM   = 3'd2,
    ST_NOT_PCM    = 3'd3,
    ST_NO_FORMAT  = 3'd4,
    ST_NO_DATA    = 3'd5,
    ST_SHORT      = 3'd6
  } status_t;

  localparam logic [31:0] TAG_FORM = 32'h464F524D;
  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_AIFF = 32'h41494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_COMM = 32'h434F4D4D;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_SSND = 32'h53534E44;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  localparam logic [31:0] EXT_44K = 32'h400EAC44;
  localparam logic [31:0] EXT_22K = 32'h400DAC44;
  localparam logic [31:0] RATE_44K = 32'd44100;
  localparam logic [31:0] RATE_22K = 32'd22050;
  localparam logic [31:0] RATE_11K = 32'd11025;

  localparam logic [4:0] COMM_FIELD_BYTES = 5'd12;
  localparam logic [4:0] FMT_FIELD_BYTES  = 5'd16;
  localparam logic [4:0] SSND_MIN_BYTES   = 5'd8;

  localparam int FL_LE = 0;
  localparam int FL_ST = 1;
  localparam int FL_16 = 2;
  localparam int FL_S8 = 3;

endpackage

`default_nettype wire

@@ design/wav_aiff_header_parser_core.sv @@
// Top level of the WAV/AIFF header parser: byte stream in, one format report per file out.
// Depends on wahp_pkg for tags, status codes and phase encoding.
`default_nettype none

// The parser takes one file byte in every clock cycle and never needs a gap between
// bytes; in_file_start marks offset zero of a new file and restarts parsing. Each byte
// is handled completely in the cycle it is transferred, and the single report for a
// file is loaded into the output register at the edge of the byte that completes it,
// so it is visible from the next cycle on. The longest path is the chunk end computation
// (offset plus size plus pad) and its compare against the form size. Input transfers
// stall only while a finished report is waiting and the output side is stalled.
// Bytes before the first file start and after a report are accepted and ignored.
module wav_aiff_header_parser_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_file_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_parse_status,
  output logic             out_little_endian_samples,
  output logic             out_two_channels,
  output logic             out_sixteen_bit_samples,
  output logic             out_signed_byte_samples,
  output logic [31:0]      out_rate_hz,
  output logic [2:0]       out_frame_bytes,
  output logic [31:0]      out_data_start,
  output logic [31:0]      out_data_bytes
);

  wahp_pkg::phase_t phase_r, phase_nxt, phase_e;
  logic [31:0] offset_r, offset_nxt, offset_e;
  logic [31:0] shift_r, shift_nxt, shift_e;
  logic [31:0] tag_r, tag_nxt, tag_e;
  logic [32:0] cend_r, cend_nxt, cend_e;
  logic [31:0] form_r, form_nxt, form_e;
  logic        wave_r, wave_nxt, wave_e;
  logic [1:0]  found_r, found_nxt, found_e;
  logic [3:0]  flags_r, flags_nxt, flags_e;
  logic [31:0] rate_r, rate_nxt, rate_e;
  logic [31:0] dstart_r, dstart_nxt, dstart_e;
  logic [31:0] dbytes_r, dbytes_nxt, dbytes_e;
  logic [4:0]  fcount_r, fcount_nxt, fcount_e;

  logic        out_valid_r;
  logic [2:0]  status_r;
  logic [3:0]  oflags_r;
  logic [31:0] orate_r;
  logic [2:0]  oframe_r;
  logic [31:0] ostart_r;
  logic [31:0] obytes_r;

  logic        accept;
  logic        emit_now;
  wahp_pkg::status_t emit_status;
  logic        do_after;
  logic [31:0] cur, pos, be, le, fld, size;
  logic [4:0]  need, least;
  logic        data_tag;
  logic [15:0] v16;
  logic [2:0]  frame_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (in_file_start) begin
      phase_e  = wahp_pkg::PH_PRE;
      offset_e = '0;
      shift_e  = '0;
      tag_e    = '0;
      cend_e   = '0;
      form_e   = '0;
      wave_e   = 1'b0;
      found_e  = '0;
      flags_e  = '0;
      rate_e   = '0;
      dstart_e = '0;
      dbytes_e = '0;
      fcount_e = '0;
    end else begin
      phase_e  = phase_r;
      offset_e = offset_r;
      shift_e  = shift_r;
      tag_e    = tag_r;
      cend_e   = cend_r;
      form_e   = form_r;
      wave_e   = wave_r;
      found_e  = found_r;
      flags_e  = flags_r;
      rate_e   = rate_r;
      dstart_e = dstart_r;
      dbytes_e = dbytes_r;
      fcount_e = fcount_r;
    end
  end

  always_comb begin
    phase_nxt   = phase_e;
    offset_nxt  = offset_e;
    shift_nxt   = shift_e;
    tag_nxt     = tag_e;
    cend_nxt    = cend_e;
    form_nxt    = form_e;
    wave_nxt    = wave_e;
    found_nxt   = found_e;
    flags_nxt   = flags_e;
    rate_nxt    = rate_e;
    dstart_nxt  = dstart_e;
    dbytes_nxt  = dbytes_e;
    fcount_nxt  = fcount_e;
    emit_now    = 1'b0;
    emit_status = wahp_pkg::ST_OK;
    do_after    = 1'b0;
    cur         = offset_e;
    pos         = offset_e + 32'd1;
    be          = {shift_e[23:0], in_byte_value};
    le          = {in_byte_value, shift_e[31:8]};
    fld         = wave_e ? le : be;
    size        = fld;
    need        = '0;
    least       = '0;
    data_tag    = 1'b0;
    v16         = wave_e ? fld[31:16] : fld[15:0];

    unique case (phase_e)
      wahp_pkg::PH_PRE: begin
        offset_nxt = pos;
        if (cur < 32'd4) begin
          shift_nxt = be;
          if (cur == 32'd3) begin
            if (be == wahp_pkg::TAG_FORM) begin
              wave_nxt = 1'b0;
            end else if (be == wahp_pkg::TAG_RIFF) begin
              wave_nxt = 1'b1;
            end else begin
              emit_now    = 1'b1;
              emit_status = wahp_pkg::ST_BAD_MAGIC;
            end
          end
        end else if (cur < 32'd8) begin
          shift_nxt = fld;
          if (cur == 32'd7) begin
            form_nxt = fld;
          end
        end else begin
          shift_nxt = be;
          if (cur == 32'd11) begin
            if (be != (wave_e ? wahp_pkg::TAG_WAVE : wahp_pkg::TAG_AIFF)) begin
              emit_now    = 1'b1;
              emit_status = wahp_pkg::ST_BAD_FORM;
            end else begin
              fcount_nxt = '0;
              phase_nxt  = wahp_pkg::PH_HDR;
            end
          end
        end
      end
      wahp_pkg::PH_HDR: begin
        offset_nxt = pos;
        fcount_nxt = fcount_e + 5'd1;
        if (fcount_e < 5'd4) begin
          tag_nxt = {tag_e[23:0], in_byte_value};
        end else begin
          shift_nxt = fld;
        end
        if (fcount_e >= 5'd7) begin
          if (tag_nxt == wahp_pkg::TAG_COMM) begin
            need = wahp_pkg::COMM_FIELD_BYTES;
          end else if (tag_nxt == wahp_pkg::TAG_FMT) begin
            need = wahp_pkg::FMT_FIELD_BYTES;
          end
          least    = need;
          cend_nxt = {1'b0, pos} + {1'b0, size} + {32'd0, size[0]};
          if (!wave_e && tag_nxt == wahp_pkg::TAG_SSND) begin
            least    = wahp_pkg::SSND_MIN_BYTES;
            data_tag = 1'b1;
          end else if (wave_e && tag_nxt == wahp_pkg::TAG_DATA) begin
            data_tag = 1'b1;
          end else if ((tag_nxt == wahp_pkg::TAG_COMM) == wave_e) begin
            need  = '0;
            least = '0;
          end
          if (size < {27'd0, least}) begin
            emit_now    = 1'b1;
            emit_status = wahp_pkg::ST_SHORT;
          end else if (need != 5'd0) begin
            found_nxt[0]            = 1'b1;
            flags_nxt[wahp_pkg::FL_LE] = wave_e;
            flags_nxt[wahp_pkg::FL_S8] = !wave_e;
            fcount_nxt              = '0;
            phase_nxt               = wahp_pkg::PH_FIELDS;
          end else begin
            if (data_tag) begin
              found_nxt[1] = 1'b1;
              dbytes_nxt   = size;
              dstart_nxt   = wave_e ? pos : pos + 32'd8;
            end
            do_after = 1'b1;
          end
        end
      end
      wahp_pkg::PH_FIELDS: begin
        offset_nxt = pos;
        shift_nxt  = fld;
        fcount_nxt = fcount_e + 5'd1;
        if (!wave_e) begin
          if (fcount_e == 5'd1) begin
            flags_nxt[wahp_pkg::FL_ST] = (v16 == 16'd2);
          end else if (fcount_e == 5'd7) begin
            flags_nxt[wahp_pkg::FL_16] = (v16 == 16'd16);
          end else if (fcount_e == 5'd11) begin
            if (fld == wahp_pkg::EXT_44K) begin
              rate_nxt = wahp_pkg::RATE_44K;
            end else if (fld == wahp_pkg::EXT_22K) begin
              rate_nxt = wahp_pkg::RATE_22K;
            end else begin
              rate_nxt = wahp_pkg::RATE_11K;
            end
          end
        end else begin
          if (fcount_e == 5'd1) begin
            if (v16 != 16'd1) begin
              emit_now    = 1'b1;
              emit_status = wahp_pkg::ST_NOT_PCM;
            end
          end else if (fcount_e == 5'd3) begin
            flags_nxt[wahp_pkg::FL_ST] = (v16 == 16'd2);
          end else if (fcount_e == 5'd7) begin
            rate_nxt = fld;
          end else if (fcount_e == 5'd15) begin
            flags_nxt[wahp_pkg::FL_16] = (v16 == 16'd16);
          end
        end
        if (tag_e == wahp_pkg::TAG_COMM) begin
          need = wahp_pkg::COMM_FIELD_BYTES;
        end else if (tag_e == wahp_pkg::TAG_FMT) begin
          need = wahp_pkg::FMT_FIELD_BYTES;
        end
        if (!emit_now && fcount_nxt >= need) begin
          do_after = 1'b1;
        end
      end
      wahp_pkg::PH_SKIP: begin
        offset_nxt = pos;
        if ({1'b0, pos} == cend_e) begin
          fcount_nxt = '0;
          phase_nxt  = wahp_pkg::PH_HDR;
        end
      end
      default: begin
      end
    endcase

    if (do_after) begin
      if (cend_nxt >= {1'b0, form_e}) begin
        emit_now = 1'b1;
        if (!found_nxt[0]) begin
          emit_status = wahp_pkg::ST_NO_FORMAT;
        end else if (!found_nxt[1]) begin
          emit_status = wahp_pkg::ST_NO_DATA;
        end else begin
          emit_status = wahp_pkg::ST_OK;
        end
      end else begin
        fcount_nxt = '0;
        phase_nxt  = ({1'b0, pos} == cend_nxt) ? wahp_pkg::PH_HDR : wahp_pkg::PH_SKIP;
      end
    end

    if (emit_now) begin
      phase_nxt = wahp_pkg::PH_DONE;
    end

    unique case (flags_nxt[wahp_pkg::FL_16:wahp_pkg::FL_ST])
      2'b00:   frame_nxt = 3'd1;
      2'b01:   frame_nxt = 3'd2;
      2'b10:   frame_nxt = 3'd2;
      default: frame_nxt = 3'd4;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wahp_pkg::PH_IDLE;
      offset_r <= '0;
      shift_r  <= '0;
      tag_r    <= '0;
      cend_r   <= '0;
      form_r   <= '0;
      wave_r   <= 1'b0;
      found_r  <= '0;
      flags_r  <= '0;
      rate_r   <= '0;
      dstart_r <= '0;
      dbytes_r <= '0;
      fcount_r <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      offset_r <= offset_nxt;
      shift_r  <= shift_nxt;
      tag_r    <= tag_nxt;
      cend_r   <= cend_nxt;
      form_r   <= form_nxt;
      wave_r   <= wave_nxt;
      found_r  <= found_nxt;
      flags_r  <= flags_nxt;
      rate_r   <= rate_nxt;
      dstart_r <= dstart_nxt;
      dbytes_r <= dbytes_nxt;
      fcount_r <= fcount_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && emit_now) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit_now) begin
      status_r <= emit_status;
      if (emit_status != wahp_pkg::ST_OK) begin
        oflags_r <= '0;
        orate_r  <= '0;
        oframe_r <= 3'd1;
        ostart_r <= '0;
        obytes_r <= '0;
      end else begin
        oflags_r <= flags_nxt;
        orate_r  <= rate_nxt;
        oframe_r <= frame_nxt;
        ostart_r <= dstart_nxt;
        obytes_r <= dbytes_nxt;
      end
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_parse_status          = status_r;
  assign out_little_endian_samples = oflags_r[wahp_pkg::FL_LE];
  assign out_two_channels          = oflags_r[wahp_pkg::FL_ST];
  assign out_sixteen_bit_samples   = oflags_r[wahp_pkg::FL_16];
  assign out_signed_byte_samples   = oflags_r[wahp_pkg::FL_S8];
  assign out_rate_hz               = orate_r;
  assign out_frame_bytes           = oframe_r;
  assign out_data_start            = ostart_r;
  assign out_data_bytes            = obytes_r;

  a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_parse_status != wahp_pkg::ST_OK |->
      out_rate_hz == 32'd0 && out_frame_bytes == 3'd1 && out_data_bytes == 32'd0)
    else $error("error report carries nonzero format fields");

  a_frame_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_parse_status == wahp_pkg::ST_OK |->
      out_frame_bytes == (out_two_channels ? 3'd2 : 3'd1) *
                         (out_sixteen_bit_samples ? 3'd2 : 3'd1))
    else $error("frame bytes disagree with channel and sample width flags");

  a_done_after_report: assert property (@(posedge clk) disable iff (!rst_n)
    accept && emit_now |=> phase_r == wahp_pkg::PH_DONE && out_valid)
    else $error("report transfer did not end the parse");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_parse_status != 3'd7)
    else $error("report status out of range");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == wahp_pkg::PH_IDLE |-> found_r == 2'd0 && offset_r == 32'd0)
    else $error("idle parser holds stale chunk state");

endmodule

`default_nettype wire

@@ dv/wahp_report_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the WAV/AIFF header parser: follows every byte transfer, predicts the
// format report of each file and compares it with the reports that leave the block.
// Depends on wahp_pkg for chunk tags, status codes, phase encoding and flag positions.
module wahp_report_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_file_start,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_parse_status,
  input  logic        out_little_endian_samples,
  input  logic        out_two_channels,
  input  logic        out_sixteen_bit_samples,
  input  logic        out_signed_byte_samples,
  input  logic [31:0] out_rate_hz,
  input  logic [2:0]  out_frame_bytes,
  input  logic [31:0] out_data_start,
  input  logic [31:0] out_data_bytes,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [2:0]  status;
    logic        le;
    logic        two_ch;
    logic        wide;
    logic        signed8;
    logic [31:0] rate;
    logic [2:0]  frame;
    logic [31:0] start;
    logic [31:0] length;
  } report_t;

  report_t reports_due[$];

  wahp_pkg::phase_t phase;
  logic [31:0] offset;
  logic [31:0] shifter;
  logic [31:0] tag;
  logic [32:0] chunk_end;
  logic [31:0] form_size;
  logic        wave;
  logic [1:0]  found;
  logic [3:0]  flags;
  logic [31:0] rate_q;
  logic [31:0] data_start_q;
  logic [31:0] data_bytes_q;
  int unsigned field_pos;

  function automatic logic [4:0] field_bytes(input logic [31:0] t);
    if (t == wahp_pkg::TAG_COMM) return wahp_pkg::COMM_FIELD_BYTES;
    if (t == wahp_pkg::TAG_FMT) return wahp_pkg::FMT_FIELD_BYTES;
    return 5'd0;
  endfunction

  task automatic clear_parser();
    phase = wahp_pkg::PH_IDLE;
    offset = '0;
    shifter = '0;
    tag = '0;
    chunk_end = '0;
    form_size = '0;
    wave = 1'b0;
    found = '0;
    flags = '0;
    rate_q = '0;
    data_start_q = '0;
    data_bytes_q = '0;
    field_pos = 0;
  endtask

  task automatic close_file(input wahp_pkg::status_t code);
    report_t r;
    r = '0;
    r.status = code;
    r.frame = 3'd1;
    if (code == wahp_pkg::ST_OK) begin
      r.le = flags[wahp_pkg::FL_LE];
      r.two_ch = flags[wahp_pkg::FL_ST];
      r.wide = flags[wahp_pkg::FL_16];
      r.signed8 = flags[wahp_pkg::FL_S8];
      r.rate = rate_q;
      r.frame = (flags[wahp_pkg::FL_ST] ? 3'd2 : 3'd1) *
                (flags[wahp_pkg::FL_16] ? 3'd2 : 3'd1);
      r.start = data_start_q;
      r.length = data_bytes_q;
    end
    phase = wahp_pkg::PH_DONE;
    reports_due.push_back(r);
  endtask

  task automatic end_scan();
    if (!found[0]) close_file(wahp_pkg::ST_NO_FORMAT);
    else if (!found[1]) close_file(wahp_pkg::ST_NO_DATA);
    else close_file(wahp_pkg::ST_OK);
  endtask

  task automatic chunk_done(input logic [31:0] next_pos);
    if (chunk_end >= {1'b0, form_size}) begin
      end_scan();
    end else begin
      field_pos = 0;
      if (chunk_end == {1'b0, next_pos}) phase = wahp_pkg::PH_HDR;
      else phase = wahp_pkg::PH_SKIP;
    end
  endtask

  task automatic header_done(input logic [31:0] pos);
    logic [31:0] chunk_size;
    logic [4:0]  need;
    logic [4:0]  least;
    logic        data_tag;
    chunk_size = shifter;
    need = field_bytes(tag);
    least = need;
    data_tag = 1'b0;
    chunk_end = {1'b0, pos} + {1'b0, chunk_size} + {32'd0, chunk_size[0]};
    if (!wave && tag == wahp_pkg::TAG_SSND) begin
      least = wahp_pkg::SSND_MIN_BYTES;
      data_tag = 1'b1;
    end else if (wave && tag == wahp_pkg::TAG_DATA) begin
      data_tag = 1'b1;
    end else if ((tag == wahp_pkg::TAG_COMM) == wave) begin
      need = 5'd0;
      least = 5'd0;
    end
    if (chunk_size < least) begin
      close_file(wahp_pkg::ST_SHORT);
    end else if (need != 0) begin
      found[0] = 1'b1;
      flags[wahp_pkg::FL_LE] = wave;
      flags[wahp_pkg::FL_S8] = !wave;
      field_pos = 0;
      phase = wahp_pkg::PH_FIELDS;
    end else begin
      if (data_tag) begin
        found[1] = 1'b1;
        data_bytes_q = chunk_size;
        data_start_q = wave ? pos : pos + 32'd8;
      end
      chunk_done(pos);
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic first);
    logic [31:0] cur;
    logic [31:0] nxt;
    logic [31:0] be;
    logic [31:0] le;
    logic [15:0] v16;
    int unsigned r;
    if (first) begin
      clear_parser();
      phase = wahp_pkg::PH_PRE;
    end else if (phase == wahp_pkg::PH_IDLE || phase == wahp_pkg::PH_DONE) begin
      return;
    end
    cur = offset;
    offset = cur + 32'd1;
    nxt = offset;
    be = {shifter[23:0], b};
    le = {b, shifter[31:8]};
    case (phase)
      wahp_pkg::PH_PRE: begin
        if (cur < 4) begin
          shifter = be;
          if (cur == 3) begin
            if (shifter == wahp_pkg::TAG_FORM) wave = 1'b0;
            else if (shifter == wahp_pkg::TAG_RIFF) wave = 1'b1;
            else close_file(wahp_pkg::ST_BAD_MAGIC);
          end
        end else if (cur < 8) begin
          shifter = wave ? le : be;
          if (cur == 7) form_size = shifter;
        end else begin
          shifter = be;
          if (cur == 11) begin
            if (shifter != (wave ? wahp_pkg::TAG_WAVE : wahp_pkg::TAG_AIFF)) begin
              close_file(wahp_pkg::ST_BAD_FORM);
            end else begin
              field_pos = 0;
              phase = wahp_pkg::PH_HDR;
            end
          end
        end
      end
      wahp_pkg::PH_HDR: begin
        r = field_pos;
        field_pos = field_pos + 1;
        if (r < 4) tag = {tag[23:0], b};
        else shifter = wave ? le : be;
        if (r >= 7) header_done(nxt);
      end
      wahp_pkg::PH_FIELDS: begin
        shifter = wave ? le : be;
        r = field_pos;
        field_pos = field_pos + 1;
        if (!wave) begin
          v16 = shifter[15:0];
          if (r == 1) begin
            flags[wahp_pkg::FL_ST] = (v16 == 16'd2);
          end else if (r == 7) begin
            flags[wahp_pkg::FL_16] = (v16 == 16'd16);
          end else if (r == 11) begin
            if (shifter == wahp_pkg::EXT_44K) rate_q = wahp_pkg::RATE_44K;
            else if (shifter == wahp_pkg::EXT_22K) rate_q = wahp_pkg::RATE_22K;
            else rate_q = wahp_pkg::RATE_11K;
          end
        end else begin
          v16 = shifter[31:16];
          if (r == 1) begin
            if (v16 != 16'd1) begin
              close_file(wahp_pkg::ST_NOT_PCM);
              return;
            end
          end else if (r == 3) begin
            flags[wahp_pkg::FL_ST] = (v16 == 16'd2);
          end else if (r == 7) begin
            rate_q = shifter;
          end else if (r == 15) begin
            flags[wahp_pkg::FL_16] = (v16 == 16'd16);
          end
        end
        if (field_pos >= field_bytes(tag)) chunk_done(nxt);
      end
      wahp_pkg::PH_SKIP: begin
        if ({1'b0, nxt} == chunk_end) begin
          field_pos = 0;
          phase = wahp_pkg::PH_HDR;
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want_v);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want_v);
    fail_count++;
  endtask

  task automatic check_report();
    report_t want;
    if (reports_due.size() == 0) begin
      note_mismatch("report with none expected, status", 32'(out_parse_status), 32'd0);
      return;
    end
    want = reports_due.pop_front();
    if (out_parse_status !== want.status)
      note_mismatch("parse_status", 32'(out_parse_status), 32'(want.status));
    if (out_little_endian_samples !== want.le)
      note_mismatch("little_endian_samples", 32'(out_little_endian_samples), 32'(want.le));
    if (out_two_channels !== want.two_ch)
      note_mismatch("two_channels", 32'(out_two_channels), 32'(want.two_ch));
    if (out_sixteen_bit_samples !== want.wide)
      note_mismatch("sixteen_bit_samples", 32'(out_sixteen_bit_samples), 32'(want.wide));
    if (out_signed_byte_samples !== want.signed8)
      note_mismatch("signed_byte_samples", 32'(out_signed_byte_samples), 32'(want.signed8));
    if (out_rate_hz !== want.rate)
      note_mismatch("rate_hz", out_rate_hz, want.rate);
    if (out_frame_bytes !== want.frame)
      note_mismatch("frame_bytes", 32'(out_frame_bytes), 32'(want.frame));
    if (out_data_start !== want.start)
      note_mismatch("data_start", out_data_start, want.start);
    if (out_data_bytes !== want.length)
      note_mismatch("data_bytes", out_data_bytes, want.length);
  endtask

  // A report transfer is checked before the byte transfer of the same edge, since a
  // report always belongs to a byte taken at an earlier edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      reports_due.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (out_valid && !out_stall) check_report();
      if (in_valid && !in_stall) parse_byte(in_byte_value, in_file_start);
      pending = reports_due.size();
    end
  end

endmodule

@@ dv/wav_aiff_header_parser_core_tb.sv @@
`timescale 1ns / 1ps
// Top of the header parser testbench: clock, reset, sound file byte stream and verdict.
// Depends on wav_aiff_header_parser_core, wahp_report_checker and wahp_pkg.
module wav_aiff_header_parser_core_tb;

  localparam int RANDOM_BYTES = 1750;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [31:0] EXT_11K = 32'h400CAC44;

  typedef enum int { CK_FORMAT, CK_DATA, CK_OTHER } chunk_kind_t;

  typedef struct packed {
    logic [7:0] value;
    logic       start;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_value = 8'h00;
  logic        in_file_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_parse_status;
  logic        out_little_endian_samples;
  logic        out_two_channels;
  logic        out_sixteen_bit_samples;
  logic        out_signed_byte_samples;
  logic [31:0] out_rate_hz;
  logic [2:0]  out_frame_bytes;
  logic [31:0] out_data_start;
  logic [31:0] out_data_bytes;
  int          fail_count;
  int          pending;
  int unsigned cycle_no = 0;
  int unsigned idle_run = 0;
  logic        quiet;

  stream_byte_t byte_stream[$];
  logic [7:0]   file_q[$];

  wav_aiff_header_parser_core dut (.*);

  wahp_report_checker report_chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  assign quiet = (cycle_no >= 1500) && (cycle_no < 2300);

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  always @(negedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 30);
  end

  task automatic push_stream(input logic [7:0] v, input logic first);
    byte_stream.push_back('{value: v, start: first});
  endtask

  task automatic flush_file();
    int k;
    for (k = 0; k < file_q.size(); k++) push_stream(file_q[k], k == 0);
    file_q.delete();
  endtask

  task automatic put_word(input logic [31:0] v, input logic little, input int n);
    int k;
    for (k = 0; k < n; k++) file_q.push_back(little ? v[8*k +: 8] : v[8*(n-1-k) +: 8]);
  endtask

  function automatic logic [15:0] pick_channels();
    case ($urandom_range(3))
      0: return 16'd1;
      1, 2: return 16'd2;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_bits();
    case ($urandom_range(3))
      0: return 16'd8;
      1, 2: return 16'd16;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic put_format_fields(input logic wave);
    logic [31:0] v;
    if (!wave) begin
      put_word(32'(pick_channels()), 1'b0, 2);
      put_word($urandom(), 1'b0, 4);
      put_word(32'(pick_bits()), 1'b0, 2);
      case ($urandom_range(3))
        0: v = wahp_pkg::EXT_44K;
        1: v = wahp_pkg::EXT_22K;
        2: v = EXT_11K;
        default: v = $urandom();
      endcase
      put_word(v, 1'b0, 4);
      put_word($urandom(), 1'b0, 4);
      put_word($urandom(), 1'b0, 2);
    end else begin
      put_word(($urandom_range(99) < 85) ? 32'd1 : $urandom(), 1'b1, 2);
      put_word(32'(pick_channels()), 1'b1, 2);
      case ($urandom_range(3))
        0: v = wahp_pkg::RATE_44K;
        1: v = wahp_pkg::RATE_22K;
        2: v = 32'd8000;
        default: v = $urandom();
      endcase
      put_word(v, 1'b1, 4);
      put_word($urandom(), 1'b1, 4);
      put_word($urandom(), 1'b1, 2);
      put_word(32'(pick_bits()), 1'b1, 2);
    end
  endtask

  task automatic build_file();
    chunk_kind_t kinds[$];
    logic [32:0] ends[$];
    logic [32:0] chunk_stop;
    logic [31:0] tag_v;
    logic [31:0] chunk_size;
    logic [31:0] form_val;
    logic        wave;
    logic        last;
    int          need;
    int          head;
    int          fill_to;
    int          pick;
    int          i;
    int          cut;
    file_q.delete();
    wave = 1'($urandom_range(1));
    if ($urandom_range(99) < 75) begin
      if ($urandom_range(3) == 0) kinds.push_back(CK_OTHER);
      kinds.push_back(CK_FORMAT);
      if ($urandom_range(3) == 0) kinds.push_back(CK_OTHER);
      kinds.push_back(CK_DATA);
    end else begin
      repeat ($urandom_range(1, 4)) kinds.push_back(chunk_kind_t'($urandom_range(2)));
    end
    put_word(wave ? wahp_pkg::TAG_RIFF : wahp_pkg::TAG_FORM, 1'b0, 4);
    put_word(32'd0, 1'b0, 4);
    put_word(wave ? wahp_pkg::TAG_WAVE : wahp_pkg::TAG_AIFF, 1'b0, 4);
    for (i = 0; i < kinds.size(); i++) begin
      last = (i == kinds.size() - 1);
      head = file_q.size();
      case (kinds[i])
        CK_FORMAT: begin
          tag_v = wave ? wahp_pkg::TAG_FMT : wahp_pkg::TAG_COMM;
          need = int'(wave ? wahp_pkg::FMT_FIELD_BYTES : wahp_pkg::COMM_FIELD_BYTES);
          pick = $urandom_range(99);
          if (pick < 80) chunk_size = wave ? 32'd16 : 32'd18;
          else if (pick < 90) chunk_size = (wave ? 32'd16 : 32'd18) + $urandom_range(3);
          else chunk_size = $urandom_range(need - 1);
        end
        CK_DATA: begin
          tag_v = wave ? wahp_pkg::TAG_DATA : wahp_pkg::TAG_SSND;
          if (last && $urandom_range(3) == 0) chunk_size = $urandom();
          else chunk_size = $urandom_range(40);
        end
        default: begin
          case ($urandom_range(3))
            0: tag_v = wave ? wahp_pkg::TAG_COMM : wahp_pkg::TAG_FMT;
            1: tag_v = wave ? wahp_pkg::TAG_SSND : wahp_pkg::TAG_DATA;
            default: tag_v = $urandom();
          endcase
          chunk_size = $urandom_range(24);
        end
      endcase
      put_word(tag_v, 1'b0, 4);
      put_word(chunk_size, wave, 4);
      chunk_stop = 33'(file_q.size()) + {1'b0, chunk_size} + {32'd0, chunk_size[0]};
      ends.push_back(chunk_stop);
      if (kinds[i] == CK_FORMAT) put_format_fields(wave);
      if (chunk_size > 32'd64) fill_to = head + 8 + $urandom_range(3);
      else fill_to = head + 8 + int'(chunk_size);
      while (file_q.size() > fill_to) file_q.delete(file_q.size() - 1);
      while (file_q.size() < fill_to) file_q.push_back(8'($urandom()));
      if (chunk_size[0] && chunk_size <= 32'd64) file_q.push_back(8'($urandom()));
    end
    pick = $urandom_range(99);
    if (pick < 80) chunk_stop = ends[ends.size() - 1] - 33'($urandom_range(2));
    else if (pick < 92) chunk_stop = ends[$urandom_range(ends.size() - 1)];
    else chunk_stop = 33'($urandom());
    form_val = chunk_stop[32] ? 32'hFFFFFFFF : chunk_stop[31:0];
    for (i = 0; i < 4; i++) file_q[4 + i] = wave ? form_val[8*i +: 8] : form_val[8*(3-i) +: 8];
    pick = $urandom_range(99);
    if (pick < 8) begin
      i = $urandom_range(11);
      file_q[i] = file_q[i] ^ (8'h01 << $urandom_range(7));
    end else if (pick < 16) begin
      cut = $urandom_range(1, file_q.size() - 1);
      while (file_q.size() > cut) file_q.delete(file_q.size() - 1);
    end
  endtask

  initial begin
    int directed_len;
    int i;
    push_stream(8'h00, 1'b0);
    push_stream(8'hFF, 1'b0);
    put_word({wahp_pkg::TAG_RIFF[31:8], 8'hFF}, 1'b0, 4);
    flush_file();
    put_word(wahp_pkg::TAG_FORM, 1'b0, 4);
    put_word(32'hFFFFFFFF, 1'b0, 4);
    put_word({wahp_pkg::TAG_AIFF[31:8], 8'h00}, 1'b0, 4);
    flush_file();
    push_stream(8'hFF, 1'b0);
    directed_len = byte_stream.size();
    while (byte_stream.size() < directed_len + RANDOM_BYTES) begin
      if ($urandom_range(99) < 8) begin
        repeat ($urandom_range(1, 6)) push_stream(8'($urandom()), $urandom_range(9) == 0);
      end else begin
        build_file();
        flush_file();
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (i = 0; i < byte_stream.size(); i++) begin
      while (!quiet && $urandom_range(99) < 30) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      in_byte_value <= byte_stream[i].value;
      in_file_start <= byte_stream[i].start;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
